[rtl/ffba_pkg.sv]
// ---------------------------------------------------------------------------
// ffba_pkg
// shared types and codes for the first-fit block allocator
// ---------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_CALLOC  = 3'd1;
    localparam logic [2:0] CMD_FREE    = 3'd2;
    localparam logic [2:0] CMD_REALLOC = 3'd3;
    localparam logic [2:0] CMD_STATS   = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_BAD  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_IGN  = 3'd3;
    localparam logic [2:0] ST_UNK  = 3'd4;

    localparam logic [42:0] SIZE_LIMIT = 43'd100000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_FIND,
        S_FIND_CHK,
        S_GRANT,
        S_GRANT_CHK,
        S_APPEND,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

[rtl/first_fit_block_allocator_core.sv]
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core
// first-fit allocator over an upward-growing heap with a block table
// ---------------------------------------------------------------------------
// One command is processed at a time. A command passes through the setup
// states S_MUL and S_CHECK, visits each table entry in a read state and a
// check state, ends a walk that reaches the end of the table in its read state,
// appends in S_APPEND when an allocation finds no fit and finishes in S_DONE.
// The address lookup and the first-fit search each walk the block table through
// its single registered read port. A realloc that moves can walk the table twice.
// The result stays on the master side until taken; s_axis_tready is high only
// when the sequencer is idle and the output register is empty.
`default_nettype none
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 64,
    parameter int HEAP_BYTES = 1048576,
    parameter int META_BYTES = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // cmd[2:0], req_size[29:3], elem_count[45:30], addr[66:46], zero pad
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], result_addr[23:3], copy_from[44:24], copy_bytes[65:45],
    // free_blocks[72:66], free_bytes[93:73], total_blocks[100:94],
    // total_bytes[121:101], header_bytes[142:122], zero pad
    output logic [143:0]      m_axis_tdata
);
    import ffba_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int HW = $clog2(HEAP_BYTES + 1) + 1;

    logic [20:0] mem_start [MAX_BLOCKS];
    logic [20:0] mem_bytes [MAX_BLOCKS];
    logic        mem_free  [MAX_BLOCKS];
    logic [20:0] rd_start, rd_bytes;
    logic        rd_free;

    state_t state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [26:0] sz_reg;
    logic [15:0] cnt_reg;
    logic [20:0] a_reg;
    logic [42:0] n_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] hit_reg;
    logic [20:0] hit_bytes_reg;
    logic [CW-1:0] total_reg;
    logic [HW-1:0] top_reg;
    logic [CW-1:0] fcnt_reg;
    logic [HW-1:0] fsum_reg;
    logic [20:0] hdr_reg;
    logic [2:0]  st_reg;
    logic [20:0] res_reg, cfrom_reg, cbytes_reg;
    logic        ovalid_reg;

    logic [2:0]  in_cmd;
    logic        size_bad;
    logic [43:0] need;
    logic        wr_en, wr_free;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [20:0] wr_start, wr_bytes;
    logic        scan_end, fits;

    assign in_cmd = s_axis_tdata[2:0];
    assign size_bad = (n_reg == 43'd0) || (n_reg > SIZE_LIMIT);
    assign scan_end = (idx_reg >= total_reg);
    assign fits = rd_free && ({22'd0, rd_bytes} >= n_reg);
    // full request width so that a large request cannot wrap into a small one
    assign need = 44'(top_reg) + 44'(META_BYTES) + {1'b0, n_reg};
    assign rd_idx = idx_reg[IW-1:0];
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

    // block table with one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_idx] <= wr_start;
            mem_bytes[wr_idx] <= wr_bytes;
            mem_free[wr_idx]  <= wr_free;
        end
        rd_start <= mem_start[rd_idx];
        rd_bytes <= mem_bytes[rd_idx];
        rd_free  <= mem_free[rd_idx];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_axis_tvalid && s_axis_tready) state_next = S_MUL;
            S_MUL:       state_next = S_CHECK;
            S_CHECK:
            begin
                if (cmd_reg == CMD_ALLOC || cmd_reg == CMD_CALLOC)
                    state_next = size_bad ? S_DONE : S_GRANT;
                else if (cmd_reg == CMD_FREE)
                    state_next = (a_reg == 21'd0) ? S_DONE : S_FIND;
                else if (cmd_reg == CMD_REALLOC)
                    state_next = size_bad ? S_DONE : S_FIND;
                else
                    state_next = S_DONE;
            end
            S_FIND:      state_next = scan_end ? S_DONE : S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (rd_start == a_reg)
                begin
                    if (cmd_reg == CMD_REALLOC && !rd_free
                        && {22'd0, rd_bytes} < n_reg)
                        state_next = S_GRANT;
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_FIND;
            end
            S_GRANT:     state_next = scan_end ? S_APPEND : S_GRANT_CHK;
            S_GRANT_CHK: state_next = fits ? S_DONE : S_GRANT;
            S_APPEND:    state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // table write port
    always_comb
    begin
        wr_en = 1'b0;
        wr_idx = rd_idx;
        wr_start = rd_start;
        wr_bytes = rd_bytes;
        wr_free = 1'b0;
        case (state_reg)
            S_FIND_CHK:
                if (rd_start == a_reg && cmd_reg == CMD_FREE && !rd_free)
                begin
                    wr_en = 1'b1;
                    wr_free = 1'b1;
                    wr_idx = IW'(idx_reg - CW'(1));
                end
            S_GRANT_CHK:
                if (fits)
                begin
                    wr_en = 1'b1;
                    wr_idx = IW'(idx_reg - CW'(1));
                end
            S_APPEND:
                if (total_reg < CW'(MAX_BLOCKS) && need <= 44'(HEAP_BYTES))
                begin
                    wr_en = 1'b1;
                    wr_idx = total_reg[IW-1:0];
                    wr_start = 21'(top_reg + HW'(META_BYTES));
                    wr_bytes = n_reg[20:0];
                end
            S_DONE:
                if (cmd_reg == CMD_REALLOC && st_reg == ST_OK && cfrom_reg != 21'd0)
                begin
                    wr_en = 1'b1;
                    wr_free = 1'b1;
                    wr_idx = hit_reg;
                    wr_start = a_reg;
                    wr_bytes = hit_bytes_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            total_reg  <= '0;
            top_reg    <= '0;
            fcnt_reg   <= '0;
            fsum_reg   <= '0;
            hdr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cmd_reg <= (in_cmd == CMD_REALLOC && s_axis_tdata[66:46] == 21'd0)
                                   ? CMD_ALLOC : in_cmd;
                        sz_reg  <= s_axis_tdata[29:3];
                        cnt_reg <= s_axis_tdata[45:30];
                        a_reg   <= s_axis_tdata[66:46];
                        st_reg  <= ST_OK;
                        res_reg <= '0;
                        cfrom_reg <= '0;
                        cbytes_reg <= '0;
                        idx_reg <= '0;
                    end
                S_MUL:
                    n_reg <= (cmd_reg == CMD_CALLOC) ? {16'd0, sz_reg} * {27'd0, cnt_reg}
                                                     : {16'd0, sz_reg};
                S_CHECK:
                begin
                    if (cmd_reg == CMD_ALLOC || cmd_reg == CMD_CALLOC
                        || cmd_reg == CMD_REALLOC)
                    begin
                        if (size_bad) st_reg <= ST_BAD;
                    end
                    else if (cmd_reg == CMD_FREE)
                    begin
                        if (a_reg == 21'd0) st_reg <= ST_IGN;
                    end
                    else if (cmd_reg != CMD_STATS)
                        st_reg <= ST_IGN;
                end
                S_FIND:
                    if (scan_end)
                        st_reg <= ST_UNK;
                    else
                        idx_reg <= idx_reg + CW'(1);
                S_FIND_CHK:
                    if (rd_start == a_reg)
                    begin
                        hit_reg <= IW'(idx_reg - CW'(1));
                        hit_bytes_reg <= rd_bytes;
                        if (cmd_reg == CMD_FREE)
                        begin
                            if (rd_free)
                                st_reg <= ST_IGN;
                            else
                            begin
                                fcnt_reg <= fcnt_reg + CW'(1);
                                fsum_reg <= fsum_reg + HW'(rd_bytes);
                            end
                        end
                        else if (rd_free)
                            st_reg <= ST_UNK;
                        else if ({22'd0, rd_bytes} >= n_reg)
                            res_reg <= a_reg;
                        else
                            idx_reg <= '0;
                    end
                S_GRANT:
                    if (!scan_end)
                        idx_reg <= idx_reg + CW'(1);
                S_GRANT_CHK:
                    if (fits)
                    begin
                        res_reg  <= rd_start;
                        fcnt_reg <= fcnt_reg - CW'(1);
                        fsum_reg <= fsum_reg - HW'(rd_bytes);
                        if (cmd_reg == CMD_REALLOC)
                        begin
                            cfrom_reg  <= a_reg;
                            cbytes_reg <= hit_bytes_reg;
                        end
                    end
                S_APPEND:
                    if (wr_en)
                    begin
                        res_reg   <= wr_start;
                        total_reg <= total_reg + CW'(1);
                        top_reg   <= HW'(need);
                        hdr_reg   <= hdr_reg + 21'(META_BYTES);
                        if (cmd_reg == CMD_REALLOC)
                        begin
                            cfrom_reg  <= a_reg;
                            cbytes_reg <= hit_bytes_reg;
                        end
                    end
                    else
                        st_reg <= ST_FULL;
                S_DONE:
                begin
                    if (cmd_reg == CMD_REALLOC && st_reg == ST_OK && cfrom_reg != 21'd0)
                    begin
                        fcnt_reg <= fcnt_reg + CW'(1);
                        fsum_reg <= fsum_reg + HW'(hit_bytes_reg);
                    end
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // statistics come straight from the live counters; the output valid and the
    // realloc release are both registered at the end of S_DONE, so the release is already counted
    logic [20:0] tb_bytes;
    assign tb_bytes = 21'(top_reg) - hdr_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {1'b0, hdr_reg, tb_bytes, 7'(total_reg), 21'(fsum_reg),
                           7'(fcnt_reg), cbytes_reg, cfrom_reg, res_reg, st_reg};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE && !m_axis_tvalid))
        else $error("ready outside idle");
    a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= total_reg) else $error("free count above block count");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result before processing");
endmodule
`default_nettype wire
